// ===== sv/frx_pkg.sv =====
// ----------------------------------------------------------------------------
// Framed receiver package
// Status and register codes, the result record and the CRC-16 byte update.
// ----------------------------------------------------------------------------
package frx_pkg;

  localparam logic [1:0] ST_VALID    = 2'd0;
  localparam logic [1:0] ST_LEN_BAD  = 2'd1;
  localparam logic [1:0] ST_CRC_BAD  = 2'd2;
  localparam logic [1:0] ST_OVERFLOW = 2'd3;

  localparam logic [1:0] CFG_START_BYTE = 2'd0;
  localparam logic [1:0] CFG_END_BYTE   = 2'd1;
  localparam logic [1:0] CFG_MIN_LEN    = 2'd2;

  localparam logic [7:0] START_BYTE_RST = 8'd2;
  localparam logic [7:0] END_BYTE_RST   = 8'd3;
  localparam logic [7:0] MIN_LEN_RST    = 8'd7;

  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CRC_INIT = 16'h0000;

  // Start, id, command and length ahead of the data; CRC pair and end after.
  localparam int HEADER_BYTES  = 4;
  localparam int TRAILER_BYTES = 3;

  // Must be a power of two.
  localparam int RESULT_FIFO_DEPTH = 2;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  frame_length;
    logic [7:0]  device_id;
    logic [7:0]  command_code;
    logic [7:0]  payload_len;
    logic [15:0] computed_crc;
  } frx_result_t;

  typedef struct packed {
    logic clear;
    logic absorb;
  } frx_crc_ctl_t;

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
    logic [15:0] c;
    c = crc_in ^ {data, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

// ===== sv/frx_crc.sv =====
// ----------------------------------------------------------------------------
// Framed receiver CRC tracker
// Running CRC-16 over every frame byte with a short delay line, so the CRC
// over all bytes but the last three is at hand when a byte is absorbed.
// ----------------------------------------------------------------------------
module frx_crc (
  input  logic                 clk,
  input  frx_pkg::frx_crc_ctl_t ctl,
  input  logic [7:0]           data,
  output logic [15:0]          crc_tap
);

  logic [15:0] run_r, run_nxt;
  logic [15:0] d0_r, d0_nxt;
  logic [15:0] d1_r, d1_nxt;

  always_comb begin
    run_nxt = run_r;
    d0_nxt  = d0_r;
    d1_nxt  = d1_r;
    if (ctl.clear) begin
      // A fresh frame: the delay line is all initial value after the shift.
      run_nxt = frx_pkg::crc16_byte(frx_pkg::CRC_INIT, data);
      d0_nxt  = frx_pkg::CRC_INIT;
      d1_nxt  = frx_pkg::CRC_INIT;
    end else if (ctl.absorb) begin
      run_nxt = frx_pkg::crc16_byte(run_r, data);
      d0_nxt  = run_r;
      d1_nxt  = d0_r;
    end
  end

  always_ff @(posedge clk) begin
    run_r <= run_nxt;
    d0_r  <= d0_nxt;
    d1_r  <= d1_nxt;
  end

  // Oldest tap as it stands before the current byte is absorbed.
  assign crc_tap = d1_r;

endmodule

// ===== sv/frx_front.sv =====
// ----------------------------------------------------------------------------
// Framed receiver front end
// Classifies each accepted byte, tracks the frame position and header, and
// checks length and CRC on an end byte, and reports a buffer overflow.
// ----------------------------------------------------------------------------
module frx_front #(
  parameter int RX_BUF_SIZE = 128
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_fire,
  input  logic [7:0]           in_byte,
  input  logic [7:0]           start_byte,
  input  logic [7:0]           end_byte,
  input  logic [7:0]           min_frame_length,
  output logic                 res_valid,
  output frx_pkg::frx_result_t res
);

  localparam int CW = $clog2(RX_BUF_SIZE + 2);
  localparam int LW = (CW > 9) ? CW : 9;
  localparam logic [CW-1:0] CNT_MAX   = CW'(RX_BUF_SIZE + 1);
  localparam logic [LW-1:0] BUF_LIMIT = LW'(RX_BUF_SIZE);
  localparam logic [LW-1:0] OVERHEAD  =
    LW'(frx_pkg::HEADER_BYTES + frx_pkg::TRAILER_BYTES);

  logic          receiving_r, receiving_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [7:0]    hdr0_r, hdr0_nxt;
  logic [7:0]    hdr1_r, hdr1_nxt;
  logic [7:0]    hdr2_r, hdr2_nxt;
  logic [7:0]    rec0_r, rec0_nxt;
  logic [7:0]    rec1_r, rec1_nxt;

  logic          is_start;
  logic          is_end;
  logic          overflow;
  logic          len_bad;
  logic          crc_bad;
  logic [1:0]    status;
  logic [CW-1:0] cnt_inc;
  logic [7:0]    hdr0_upd, hdr1_upd, hdr2_upd;
  logic [LW-1:0] declared;
  logic [15:0]   crc_tap;
  frx_pkg::frx_crc_ctl_t crc_ctl;

  frx_crc u_crc (
    .clk     (clk),
    .ctl     (crc_ctl),
    .data    (in_byte),
    .crc_tap (crc_tap)
  );

  always_comb begin
    is_start = !receiving_r && (in_byte == start_byte);
    is_end   = in_byte == end_byte;
    cnt_inc  = (cnt_r < CNT_MAX) ? cnt_r + CW'(1) : cnt_r;
    hdr0_upd = (cnt_r == CW'(1)) ? in_byte : hdr0_r;
    hdr1_upd = (cnt_r == CW'(2)) ? in_byte : hdr1_r;
    hdr2_upd = (cnt_r == CW'(3)) ? in_byte : hdr2_r;
    declared = LW'(hdr2_upd) + OVERHEAD;
    len_bad  = (declared != LW'(cnt_inc)) || (declared < LW'(min_frame_length)) ||
               (declared > BUF_LIMIT);
    // The two bytes ahead of the end byte carry the CRC, high byte first.
    crc_bad  = {rec0_r, rec1_r} != crc_tap;
    overflow = !is_end && (cnt_inc == CNT_MAX);

    if (!is_end) begin
      status = frx_pkg::ST_OVERFLOW;
    end else if (len_bad) begin
      status = frx_pkg::ST_LEN_BAD;
    end else if (crc_bad) begin
      status = frx_pkg::ST_CRC_BAD;
    end else begin
      status = frx_pkg::ST_VALID;
    end

    res_valid        = in_fire && receiving_r && (is_end || overflow);
    res.status       = status;
    res.frame_length = 8'(cnt_inc);
    res.device_id    = hdr0_upd;
    res.command_code = hdr1_upd;
    res.payload_len  = hdr2_upd;
    res.computed_crc = crc_tap;

    crc_ctl.clear  = in_fire && is_start;
    crc_ctl.absorb = in_fire && receiving_r;

    receiving_nxt = receiving_r;
    cnt_nxt       = cnt_r;
    hdr0_nxt      = hdr0_r;
    hdr1_nxt      = hdr1_r;
    hdr2_nxt      = hdr2_r;
    rec0_nxt      = rec0_r;
    rec1_nxt      = rec1_r;
    if (in_fire) begin
      if (!receiving_r) begin
        if (is_start) begin
          receiving_nxt = 1'b1;
          cnt_nxt       = CW'(1);
          hdr0_nxt      = 8'h00;
          hdr1_nxt      = 8'h00;
          hdr2_nxt      = 8'h00;
          rec0_nxt      = 8'h00;
          rec1_nxt      = 8'h00;
        end
      end else begin
        cnt_nxt  = cnt_inc;
        hdr0_nxt = hdr0_upd;
        hdr1_nxt = hdr1_upd;
        hdr2_nxt = hdr2_upd;
        rec0_nxt = rec1_r;
        rec1_nxt = in_byte;
        // A good frame or an overflow ends the attempt; a failed check does not.
        if ((is_end && (status == frx_pkg::ST_VALID)) || overflow) begin
          receiving_nxt = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      receiving_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      receiving_r <= receiving_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hdr0_r <= hdr0_nxt;
    hdr1_r <= hdr1_nxt;
    hdr2_r <= hdr2_nxt;
    rec0_r <= rec0_nxt;
    rec1_r <= rec1_nxt;
  end

`ifndef SYNTHESIS
  a_result_only_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> receiving_r)
    else $error("result raised outside a frame");

  a_count_saturates: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_MAX)
    else $error("byte count past its limit");

  a_overflow_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && (res.status == frx_pkg::ST_OVERFLOW)) |=> !receiving_r)
    else $error("overflow did not return to idle");

  a_good_frame_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && (res.status == frx_pkg::ST_VALID)) |=> !receiving_r)
    else $error("valid frame did not return to idle");
`endif

endmodule

// ===== sv/frx_fifo.sv =====
// ----------------------------------------------------------------------------
// Framed receiver result queue
// Short queue of result records; its head drives the result channel.
// ----------------------------------------------------------------------------
module frx_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  frx_pkg::frx_result_t push_data,
  input  logic                 pop,
  output logic                 full,
  output logic                 not_empty,
  output frx_pkg::frx_result_t head
);

  localparam int DEPTH = frx_pkg::RESULT_FIFO_DEPTH;
  localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW    = $clog2(DEPTH + 1);

  frx_pkg::frx_result_t mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [NW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  always_comb begin
    full       = count_r == NW'(DEPTH);
    not_empty  = count_r != '0;
    do_push    = push && !full;
    do_pop     = pop && not_empty;
    wr_ptr_nxt = do_push ? wr_ptr_r + PW'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + PW'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + NW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - NW'(1);
    end
    head = mem_r[rd_ptr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== sv/framed_packet_receiver_crc16_unit.sv =====
// ----------------------------------------------------------------------------
// Framed packet receiver with CRC-16 check
// Collects start/id/command/length/data/CRC/end frames from a byte stream,
// checks length and CRC-16 (poly 0x1021, init 0) and reports one status.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake            Beat
//  in_       input      in_valid/in_ready    one received byte
//  out_      output     out_valid/out_ready  one status record
//  cfg_      input      cfg_wr_en            one register write
//
// Accepts one byte per cycle. The frame tracker and CRC update finish a
// byte in the cycle it is accepted; any result goes to a two-entry queue
// whose head is the output. in_ready drops only while that queue is full.
// Reset is synchronous and needs no clearing pass.
module framed_packet_receiver_crc16_unit #(
  parameter int RX_BUF_SIZE = 128
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [7:0]  out_frame_length,
  output logic [7:0]  out_device_id,
  output logic [7:0]  out_command_code,
  output logic [7:0]  out_payload_len,
  output logic [15:0] out_computed_crc,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_wdata
);

  logic [7:0] start_byte_r;
  logic [7:0] end_byte_r;
  logic [7:0] min_len_r;
  logic       fifo_full;
  logic       in_fire;
  logic       res_valid;
  frx_pkg::frx_result_t res;
  frx_pkg::frx_result_t head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_byte_r <= frx_pkg::START_BYTE_RST;
      end_byte_r   <= frx_pkg::END_BYTE_RST;
      min_len_r    <= frx_pkg::MIN_LEN_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        frx_pkg::CFG_START_BYTE: start_byte_r <= cfg_wdata;
        frx_pkg::CFG_END_BYTE:   end_byte_r   <= cfg_wdata;
        frx_pkg::CFG_MIN_LEN:    min_len_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign in_ready = !fifo_full;
  assign in_fire  = in_valid && in_ready;

  frx_front #(
    .RX_BUF_SIZE (RX_BUF_SIZE)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_fire          (in_fire),
    .in_byte          (in_rx_byte),
    .start_byte       (start_byte_r),
    .end_byte         (end_byte_r),
    .min_frame_length (min_len_r),
    .res_valid        (res_valid),
    .res              (res)
  );

  frx_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_data (res),
    .pop       (out_ready),
    .full      (fifo_full),
    .not_empty (out_valid),
    .head      (head)
  );

  assign out_status       = head.status;
  assign out_frame_length = head.frame_length;
  assign out_device_id    = head.device_id;
  assign out_command_code = head.command_code;
  assign out_payload_len  = head.payload_len;
  assign out_computed_crc = head.computed_crc;

endmodule

// ===== tb/frx_result_checker.sv =====
// ----------------------------------------------------------------------------
// Framed receiver result checker
// Watches the byte, status and register ports of the framed receiver, keeps
// its own model of the frame tracker and CRC, and compares every status
// record field by field with the oldest predicted one.
// ----------------------------------------------------------------------------
module frx_result_checker #(
  parameter int RX_BUF_SIZE = 128
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [1:0]  out_status,
  input  logic [7:0]  out_frame_length,
  input  logic [7:0]  out_device_id,
  input  logic [7:0]  out_command_code,
  input  logic [7:0]  out_payload_len,
  input  logic [15:0] out_computed_crc,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_wdata,
  output int          fail_count,
  output int          results_pending,
  output int          bytes_in,
  output int          results_checked,
  output int          n_valid,
  output int          n_len_bad,
  output int          n_crc_bad,
  output int          n_overflow
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [7:0]  start_val;
  logic [7:0]  end_val;
  logic [7:0]  min_len;

  logic        in_frame;
  int          frame_cnt;
  logic [15:0] crc_now;
  logic [15:0] crc_hist [3];
  logic [7:0]  last_two [2];
  logic [7:0]  hdr [3];

  frx_pkg::frx_result_t status_q [$];

  // Bit-serial form of the CRC-16 update, most significant data bit first.
  function automatic logic [15:0] crc_next(input logic [15:0] crc,
                                           input logic [7:0]  b);
    logic [15:0] c;
    logic        fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[15] ^ b[i];
      c = {c[14:0], 1'b0};
      if (fb) c = c ^ frx_pkg::CRC_POLY;
    end
    return c;
  endfunction

  task automatic frame_clear();
    frame_cnt = 0;
    crc_now = frx_pkg::CRC_INIT;
    for (int i = 0; i < 3; i++) begin
      crc_hist[i] = '0;
      hdr[i] = '0;
    end
    last_two[0] = '0;
    last_two[1] = '0;
  endtask

  // The CRC history trails by three bytes so that at the end byte it holds
  // the CRC over everything ahead of the CRC pair.
  task automatic take_byte(input logic [7:0] b);
    if (frame_cnt >= 1 && frame_cnt <= 3) hdr[frame_cnt - 1] = b;
    if (frame_cnt <= RX_BUF_SIZE) frame_cnt++;
    crc_hist[2] = crc_hist[1];
    crc_hist[1] = crc_hist[0];
    crc_hist[0] = crc_now;
    crc_now = crc_next(crc_now, b);
  endtask

  task automatic queue_result(input logic [1:0] st);
    frx_pkg::frx_result_t r;
    r.status       = st;
    r.frame_length = 8'(frame_cnt);
    r.device_id    = hdr[0];
    r.command_code = hdr[1];
    r.payload_len  = hdr[2];
    r.computed_crc = crc_hist[2];
    status_q.push_back(r);
  endtask

  task automatic predict_byte(input logic [7:0] b);
    logic [7:0] crc_hi;
    logic [7:0] crc_lo;
    int         declared;
    logic [1:0] st;
    if (!in_frame) begin
      if (b == start_val) begin
        frame_clear();
        in_frame = 1'b1;
        take_byte(b);
      end
    end else begin
      take_byte(b);
      crc_hi = last_two[0];
      crc_lo = last_two[1];
      last_two[0] = last_two[1];
      last_two[1] = b;
      if (b == end_val) begin
        declared = int'(hdr[2]) + frx_pkg::HEADER_BYTES + frx_pkg::TRAILER_BYTES;
        if (declared != frame_cnt || declared < int'(min_len) ||
            declared > RX_BUF_SIZE) begin
          st = frx_pkg::ST_LEN_BAD;
        end else if ({crc_hi, crc_lo} != crc_hist[2]) begin
          st = frx_pkg::ST_CRC_BAD;
        end else begin
          st = frx_pkg::ST_VALID;
        end
        queue_result(st);
        // Only a good frame closes; a failed check keeps collecting bytes.
        if (st == frx_pkg::ST_VALID) begin
          in_frame = 1'b0;
          frame_clear();
        end
      end else if (frame_cnt > RX_BUF_SIZE) begin
        queue_result(frx_pkg::ST_OVERFLOW);
        in_frame = 1'b0;
        frame_clear();
      end
    end
  endtask

  task automatic cmp_field(input string name, input logic [15:0] want,
                           input logic [15:0] got);
    if (got !== want) begin
      fail_count++;
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    frx_pkg::frx_result_t want;
    if (!rst_n) begin
      start_val = frx_pkg::START_BYTE_RST;
      end_val   = frx_pkg::END_BYTE_RST;
      min_len   = frx_pkg::MIN_LEN_RST;
      in_frame  = 1'b0;
      frame_clear();
      status_q.delete();
    end else begin
      // A record leaving now was caused by an earlier byte, so check first.
      if (out_valid && out_ready) begin
        if (status_q.size() == 0) begin
          fail_count++;
          $display("%0t ns: unexpected status record, expected nothing, actual status %0d",
                   $time, out_status);
        end else begin
          want = status_q.pop_front();
          results_checked++;
          cmp_field("status", 16'(want.status), 16'(out_status));
          cmp_field("frame_length", 16'(want.frame_length), 16'(out_frame_length));
          cmp_field("device_id", 16'(want.device_id), 16'(out_device_id));
          cmp_field("command_code", 16'(want.command_code), 16'(out_command_code));
          cmp_field("payload_len", 16'(want.payload_len), 16'(out_payload_len));
          cmp_field("computed_crc", want.computed_crc, out_computed_crc);
          case (want.status)
            frx_pkg::ST_VALID:   n_valid++;
            frx_pkg::ST_LEN_BAD: n_len_bad++;
            frx_pkg::ST_CRC_BAD: n_crc_bad++;
            default:             n_overflow++;
          endcase
        end
      end
      if (in_valid && in_ready) begin
        bytes_in++;
        predict_byte(in_rx_byte);
      end
      if (cfg_wr_en) begin
        case (cfg_index)
          frx_pkg::CFG_START_BYTE: start_val = cfg_wdata;
          frx_pkg::CFG_END_BYTE:   end_val = cfg_wdata;
          frx_pkg::CFG_MIN_LEN:    min_len = cfg_wdata;
          default: ;
        endcase
      end
    end
    results_pending = status_q.size();
  end

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// Framed packet receiver testbench
// Feeds byte streams of good, corrupted, short, overlong and noisy frames
// under several start/end/minimum-length settings and varied back-pressure;
// the result checker predicts and compares every status record.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RX_BUF        = 128;
  localparam int MAX_DATA      = RX_BUF - frx_pkg::HEADER_BYTES - frx_pkg::TRAILER_BYTES;
  localparam int CLK_PERIOD    = 10;
  localparam int RESET_CYCLES  = 8;
  localparam int HOLD_CYCLES   = 80;
  localparam int SETTLE_CYCLES = 4;
  localparam int TIMEOUT_NS    = 4_000_000;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_rx_byte = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_status;
  logic [7:0]  out_frame_length;
  logic [7:0]  out_device_id;
  logic [7:0]  out_command_code;
  logic [7:0]  out_payload_len;
  logic [15:0] out_computed_crc;
  logic        cfg_wr_en = 1'b0;
  logic [1:0]  cfg_index = frx_pkg::CFG_START_BYTE;
  logic [7:0]  cfg_wdata = '0;

  int fail_count;
  int results_pending;
  int bytes_in;
  int results_checked;
  int n_valid;
  int n_len_bad;
  int n_crc_bad;
  int n_overflow;

  // Register values as last written, and a coarse view of whether the
  // block is inside a frame, used only to shape the stimulus.
  logic [7:0] cur_start = frx_pkg::START_BYTE_RST;
  logic [7:0] cur_end   = frx_pkg::END_BYTE_RST;
  logic [7:0] cur_min   = frx_pkg::MIN_LEN_RST;
  bit         gen_open;
  int         gen_cnt;
  int         phase_bytes;

  int send_idle_pct;
  int recv_idle_pct;
  bit hold_req;

  framed_packet_receiver_crc16_unit #(
    .RX_BUF_SIZE(RX_BUF)
  ) u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_frame_length (out_frame_length),
    .out_device_id    (out_device_id),
    .out_command_code (out_command_code),
    .out_payload_len  (out_payload_len),
    .out_computed_crc (out_computed_crc),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  frx_result_checker #(
    .RX_BUF_SIZE(RX_BUF)
  ) u_chk (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_frame_length (out_frame_length),
    .out_device_id    (out_device_id),
    .out_command_code (out_command_code),
    .out_payload_len  (out_payload_len),
    .out_computed_crc (out_computed_crc),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .fail_count       (fail_count),
    .results_pending  (results_pending),
    .bytes_in         (bytes_in),
    .results_checked  (results_checked),
    .n_valid          (n_valid),
    .n_len_bad        (n_len_bad),
    .n_crc_bad        (n_crc_bad),
    .n_overflow       (n_overflow)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Run stopped by timeout at %0t ns", $time);
    $display("tb NOT OK");
    $finish;
  end

  // Status receiver: random stalls, plus one long hold-off on request.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (!gen_open) begin
      if (b == cur_start) begin
        gen_open = 1'b1;
        gen_cnt = 1;
        phase_bytes++;
      end
    end else begin
      phase_bytes++;
      if (gen_cnt <= RX_BUF) gen_cnt++;
      if (b != cur_end && gen_cnt > RX_BUF) gen_open = 1'b0;
    end
  endtask

  function automatic logic [7:0] filler_byte();
    logic [7:0] v;
    do v = 8'($urandom_range(255)); while (v == cur_start || v == cur_end);
    return v;
  endfunction

  // Runs the open frame into overflow so the block is back to idle.
  task automatic resync();
    while (gen_open) send_byte(filler_byte());
  endtask

  task automatic maybe_resync();
    if ($urandom_range(3) != 0) resync();
  endtask

  task automatic send_frame(input int n_data, input logic [7:0] declared, input bit corrupt);
    logic [7:0]  fb [$];
    logic [15:0] crc;
    bit          was_idle;
    bit          closes;
    fb.push_back(cur_start);
    fb.push_back(8'($urandom_range(255)));
    fb.push_back(8'($urandom_range(255)));
    fb.push_back(declared);
    for (int i = 0; i < n_data; i++) fb.push_back(8'($urandom_range(255)));
    crc = frx_pkg::CRC_INIT;
    foreach (fb[i]) crc = frx_pkg::crc16_byte(crc, fb[i]);
    if (corrupt) crc = crc ^ (16'd1 << $urandom_range(15));
    fb.push_back(crc[15:8]);
    fb.push_back(crc[7:0]);
    fb.push_back(cur_end);
    closes = !corrupt &&
             (int'(declared) + frx_pkg::HEADER_BYTES + frx_pkg::TRAILER_BYTES == fb.size())
             && fb.size() >= int'(cur_min) && fb.size() <= RX_BUF;
    was_idle = !gen_open;
    foreach (fb[i]) send_byte(fb[i]);
    if (closes && was_idle) gen_open = 1'b0;
  endtask

  // Data lengths cluster just above what the minimum length allows.
  function automatic int data_len();
    int lo;
    lo = (cur_min > 7) ?
         int'(cur_min) - frx_pkg::HEADER_BYTES - frx_pkg::TRAILER_BYTES : 0;
    if ($urandom_range(9) == 0) return $urandom_range(MAX_DATA);
    lo = lo + $urandom_range(5);
    return (lo > MAX_DATA) ? MAX_DATA : lo;
  endfunction

  task automatic run_scenario();
    int         pick;
    int         n;
    logic [7:0] decl;
    pick = $urandom_range(99);
    n = data_len();
    if (pick < 55) begin
      send_frame(n, 8'(n), 1'b0);
    end else if (pick < 64) begin
      send_frame(n, 8'(n), 1'b1);
      maybe_resync();
    end else if (pick < 72) begin
      do decl = 8'($urandom_range(255)); while (decl == 8'(n));
      send_frame(n, decl, 1'b0);
      maybe_resync();
    end else if (pick < 78) begin
      // Frame cut short: start, a few bytes, then the end byte.
      send_byte(cur_start);
      repeat ($urandom_range(4)) send_byte(8'($urandom_range(255)));
      send_byte(cur_end);
      maybe_resync();
    end else if (pick < 82) begin
      if (!gen_open) send_byte(cur_start);
      resync();
    end else if (pick < 86) begin
      // End byte arriving once the buffer is already full.
      if (!gen_open) send_byte(cur_start);
      while (gen_open && gen_cnt < RX_BUF) send_byte(filler_byte());
      send_byte(cur_end);
      resync();
    end else if (pick < 92) begin
      repeat ($urandom_range(4, 1)) send_byte(8'($urandom_range(255)));
      maybe_resync();
    end else begin
      n = $urandom_range(MAX_DATA);
      send_frame(n, 8'(n), 1'b0);
    end
  endtask

  task automatic random_phase(input int budget);
    phase_bytes = 0;
    while (phase_bytes < budget) run_scenario();
    resync();
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_config(input logic [7:0] s, input logic [7:0] e, input logic [7:0] m);
    cfg_wr_en <= 1'b1;
    cfg_index <= frx_pkg::CFG_START_BYTE;
    cfg_wdata <= s;
    @(posedge clk);
    cfg_index <= frx_pkg::CFG_END_BYTE;
    cfg_wdata <= e;
    @(posedge clk);
    cfg_index <= frx_pkg::CFG_MIN_LEN;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cur_start = s;
    cur_end   = e;
    cur_min   = m;
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 7;
    recv_idle_pct = 72;
    // Directed opening under the reset settings.
    send_byte(8'h00);
    send_byte(8'hFF);
    send_frame(0, 8'd0, 1'b0);
    send_frame(3, 8'd3, 1'b0);
    send_frame(0, 8'd0, 1'b1);
    random_phase(330);
    drain();

    write_config(8'h7E, 8'h7E, 8'd7);
    random_phase(330);
    drain();

    send_idle_pct = 72;
    recv_idle_pct = 7;
    write_config(8'h00, 8'hFF, 8'd20);
    random_phase(300);
    drain();

    write_config(8'hFF, 8'h00, 8'd255);
    random_phase(140);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_config(8'($urandom_range(255)), 8'($urandom_range(255)),
                 8'($urandom_range(128, 7)));
    random_phase(250);
    drain();

    // Short frames while the receiver holds off fill the result queue.
    write_config(frx_pkg::START_BYTE_RST, frx_pkg::END_BYTE_RST, frx_pkg::MIN_LEN_RST);
    hold_req = 1'b1;
    repeat (12) send_frame(0, 8'd0, 1'b0);
    random_phase(300);
    drain();

    $display("Covered %0d bytes under six register settings, incl. equal start/end bytes.",
             bytes_in);
    $display("Checked %0d records: %0d valid, %0d length bad, %0d CRC bad, %0d overflow.",
             results_checked, n_valid, n_len_bad, n_crc_bad, n_overflow);
    if (results_pending != 0) $display("%0d status records never arrived", results_pending);
    if (fail_count == 0 && results_pending == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
